@@ hw/rtl/vpya_pkg.sv @@
`default_nettype none
package vpya_pkg;

  localparam int CoordWidthDef = 32;
  localparam int AngleFracDef  = 16;
  localparam int IntFrac       = 24;
  localparam int CordicSteps   = 28;
  localparam int CordicW       = 60;
  localparam int AngleW        = 36;
  localparam int NormMsb       = 55;
  localparam int NumCoords     = 6;
  localparam int QueueDepth    = 2;
  localparam int GainSplit     = 30;
  localparam logic [GainSplit-1:0] GainInvQ30 = 30'd652032874;
  localparam int Deg90  = 90;
  localparam int Deg180 = 180;
  localparam int Deg270 = 270;
  localparam int Deg360 = 360;

  // atan(2^-i) in degrees, q.24
  function automatic logic signed [AngleW-1:0] atan_q24(input int i);
    logic signed [AngleW-1:0] r;
    case (i)
      0:  r = 36'sd754974720;
      1:  r = 36'sd445687602;
      2:  r = 36'sd235489088;
      3:  r = 36'sd119537938;
      4:  r = 36'sd60000934;
      5:  r = 36'sd30029717;
      6:  r = 36'sd15018523;
      7:  r = 36'sd7509720;
      8:  r = 36'sd3754917;
      9:  r = 36'sd1877466;
      10: r = 36'sd938734;
      11: r = 36'sd469367;
      12: r = 36'sd234684;
      13: r = 36'sd117342;
      14: r = 36'sd58671;
      15: r = 36'sd29335;
      16: r = 36'sd14668;
      17: r = 36'sd7334;
      18: r = 36'sd3667;
      19: r = 36'sd1833;
      20: r = 36'sd917;
      21: r = 36'sd458;
      22: r = 36'sd229;
      23: r = 36'sd115;
      24: r = 36'sd57;
      25: r = 36'sd29;
      26: r = 36'sd14;
      27: r = 36'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vpya_front.sv @@
`default_nettype none
module vpya_front import vpya_pkg::*; #(
  parameter int CoordWidth = CoordWidthDef,
  localparam int DW    = CoordWidth + 1,
  localparam int InW   = ((NumCoords * CoordWidth + 7) / 8) * 8,
  localparam int ItemW = 3 * DW + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [InW-1:0]   s_axis_tdata_i,
  output logic                  item_vld_o,
  input  wire logic             item_rdy_i,
  output logic [ItemW-1:0]      item_o
);

  logic signed [DW-1:0] dx, dy, dz;
  logic                 degen;
  logic [ItemW-1:0]     item_q;
  logic                 vld_q;
  logic                 take;

  assign dx = DW'(signed'(s_axis_tdata_i[0*CoordWidth +: CoordWidth]))
            - DW'(signed'(s_axis_tdata_i[3*CoordWidth +: CoordWidth]));
  assign dy = DW'(signed'(s_axis_tdata_i[1*CoordWidth +: CoordWidth]))
            - DW'(signed'(s_axis_tdata_i[4*CoordWidth +: CoordWidth]));
  assign dz = DW'(signed'(s_axis_tdata_i[2*CoordWidth +: CoordWidth]))
            - DW'(signed'(s_axis_tdata_i[5*CoordWidth +: CoordWidth]));
  // no horizontal component: yaw undefined, fixed answer
  assign degen = (dx == '0) && (dy == '0);

  assign s_axis_tready_o = !vld_q || item_rdy_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign item_vld_o      = vld_q;
  assign item_o          = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (item_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= {degen, dz, dy, dx};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vpya_fifo.sv @@
`default_nettype none
module vpya_fifo import vpya_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_vld_i,
  output logic                  wr_rdy_o,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  rd_vld_o,
  input  wire logic             rd_rdy_i,
  output logic [Width-1:0]      rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign wr_rdy_o  = (count_q != CntW'(Depth));
  assign rd_vld_o  = (count_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign push      = wr_vld_i && wr_rdy_o;
  assign pop       = rd_vld_o && rd_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue overfilled");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("lost push");

  a_fall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && count_q == '0) |=> rd_data_o == $past(wr_data_i))
    else $error("empty queue did not present pushed item");

endmodule
`default_nettype wire

@@ hw/rtl/vpya_back.sv @@
`default_nettype none
module vpya_back import vpya_pkg::*; #(
  parameter int CoordWidth = CoordWidthDef,
  parameter int AngleFrac  = AngleFracDef,
  localparam int DW    = CoordWidth + 1,
  localparam int ItemW = 3 * DW + 1,
  localparam int NpW   = AngleFrac + 10,
  localparam int YawW  = AngleFrac + 9,
  localparam int Sh    = IntFrac - AngleFrac,
  localparam int NVld  = 2 * CordicSteps + 6,
  localparam int ShW   = $clog2(CordicW)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_vld_i,
  output logic                  item_rdy_o,
  input  wire logic [ItemW-1:0] item_i,
  output logic                  res_vld_o,
  input  wire logic             res_rdy_i,
  output logic [NpW-1:0]        neg_pitch_o,
  output logic [YawW-1:0]       yaw_angle_o
);

  localparam logic signed [AngleW-1:0] Half = (Sh > 0) ? AngleW'(1) <<< (Sh - 1) : '0;
  localparam logic signed [AngleW-1:0] Z180 = AngleW'(Deg180) <<< IntFrac;
  localparam logic signed [AngleW-1:0] Z360 = AngleW'(Deg360) <<< IntFrac;
  localparam logic signed [AngleW-1:0] Y360 = AngleW'(Deg360) <<< AngleFrac;
  localparam logic signed [NpW-1:0]    P90  = -(NpW'(Deg90) <<< AngleFrac);
  localparam logic signed [NpW-1:0]    P270 = -(NpW'(Deg270) <<< AngleFrac);

  logic            en;
  logic [NVld-1:0] vld_q;

  assign en         = !vld_q[NVld-1] || res_rdy_i;
  assign item_rdy_o = en;
  assign res_vld_o  = vld_q[NVld-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NVld-2:0], item_vld_i};
    end
  end

  // stage a: magnitudes and their maximum
  logic signed [DW-1:0] in_dx, in_dy, in_dz;
  logic        [DW-1:0] mx, my, mz, mmax;
  logic signed [DW-1:0] a_dx_q, a_dy_q, a_dz_q;
  logic        [DW-1:0] a_m_q;
  logic                 a_degen_q;

  assign in_dx = item_i[0*DW +: DW];
  assign in_dy = item_i[1*DW +: DW];
  assign in_dz = item_i[2*DW +: DW];
  assign mx    = in_dx[DW-1] ? DW'(-in_dx) : DW'(in_dx);
  assign my    = in_dy[DW-1] ? DW'(-in_dy) : DW'(in_dy);
  assign mz    = in_dz[DW-1] ? DW'(-in_dz) : DW'(in_dz);

  always_comb begin
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q    <= in_dx;
      a_dy_q    <= in_dy;
      a_dz_q    <= in_dz;
      a_m_q     <= mmax;
      a_degen_q <= item_i[ItemW-1];
    end
  end

  // stage b: normalising shift count
  logic [ShW-1:0]       msb, b_s_q;
  logic signed [DW-1:0] b_dx_q, b_dy_q, b_dz_q;
  logic                 b_degen_q;

  always_comb begin
    msb = '0;
    for (int b = 0; b < DW; b++) begin
      if (a_m_q[b]) msb = ShW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_s_q     <= ShW'(NormMsb) - msb;
      b_dx_q    <= a_dx_q;
      b_dy_q    <= a_dy_q;
      b_dz_q    <= a_dz_q;
      b_degen_q <= a_degen_q;
    end
  end

  // yaw pass, flags are {degen, dz positive, dx negative}
  logic signed [CordicW-1:0] yx_q [CordicSteps+1];
  logic signed [CordicW-1:0] yy_q [CordicSteps+1];
  logic signed [AngleW-1:0]  yz_q [CordicSteps+1];
  logic signed [CordicW-1:0] ydz_q [CordicSteps+1];
  logic [2:0]                yflg_q [CordicSteps+1];
  logic signed [CordicW-1:0] nx, ny, nz;

  assign nx = CordicW'(b_dx_q) <<< b_s_q;
  assign ny = CordicW'(b_dy_q) <<< b_s_q;
  assign nz = CordicW'(b_dz_q) <<< b_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      yx_q[0]   <= nx[CordicW-1] ? -nx : nx;
      yy_q[0]   <= nx[CordicW-1] ? -ny : ny;
      yz_q[0]   <= '0;
      ydz_q[0]  <= nz;
      yflg_q[0] <= {b_degen_q, (b_dz_q > 0), nx[CordicW-1]};
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_yaw
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!yy_q[k][CordicW-1]) begin
          yx_q[k+1] <= yx_q[k] + (yy_q[k] >>> k);
          yy_q[k+1] <= yy_q[k] - (yx_q[k] >>> k);
          yz_q[k+1] <= yz_q[k] + atan_q24(k);
        end else begin
          yx_q[k+1] <= yx_q[k] - (yy_q[k] >>> k);
          yy_q[k+1] <= yy_q[k] + (yx_q[k] >>> k);
          yz_q[k+1] <= yz_q[k] - atan_q24(k);
        end
        ydz_q[k+1]  <= ydz_q[k];
        yflg_q[k+1] <= yflg_q[k];
      end
    end
  end

  // stage f: yaw wrap and rounding, gain correction products
  logic signed [AngleW-1:0]  zq, zw, yr;
  logic        [CordicW-1:0] xu;
  logic        [YawW-1:0]    f_yaw_q;
  logic [2*GainSplit-1:0]    f_ph_q, f_pl_q;
  logic signed [CordicW-1:0] f_dz_q;
  logic [1:0]                f_flg_q;

  always_comb begin
    zq = yz_q[CordicSteps] + (yflg_q[CordicSteps][0] ? Z180 : '0);
    zw = zq[AngleW-1] ? zq + Z360 : zq;
    yr = (zw + Half) >>> Sh;
    if (yr >= Y360) yr = yr - Y360;
  end

  assign xu = yx_q[CordicSteps][CordicW-1] ? '0 : CordicW'(yx_q[CordicSteps]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_yaw_q <= YawW'(yr);
      f_ph_q  <= (2*GainSplit)'(xu[CordicW-1:GainSplit]) * (2*GainSplit)'(GainInvQ30);
      f_pl_q  <= (2*GainSplit)'(xu[GainSplit-1:0]) * (2*GainSplit)'(GainInvQ30);
      f_dz_q  <= ydz_q[CordicSteps];
      f_flg_q <= yflg_q[CordicSteps][2:1];
    end
  end

  // stage g: magnitude, start of pitch pass
  logic signed [CordicW-1:0] px_q [CordicSteps+1];
  logic signed [CordicW-1:0] py_q [CordicSteps+1];
  logic signed [AngleW-1:0]  pz_q [CordicSteps+1];
  logic [YawW-1:0]           pyaw_q [CordicSteps+1];
  logic [1:0]                pflg_q [CordicSteps+1];
  logic [2*GainSplit:0]      plr;

  assign plr = (2*GainSplit+1)'(f_pl_q) + ((2*GainSplit+1)'(1) << (GainSplit - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0]   <= CordicW'(f_ph_q) + CordicW'(plr >> GainSplit);
      py_q[0]   <= f_dz_q;
      pz_q[0]   <= '0;
      pyaw_q[0] <= f_yaw_q;
      pflg_q[0] <= f_flg_q;
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_pitch
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!py_q[k][CordicW-1]) begin
          px_q[k+1] <= px_q[k] + (py_q[k] >>> k);
          py_q[k+1] <= py_q[k] - (px_q[k] >>> k);
          pz_q[k+1] <= pz_q[k] + atan_q24(k);
        end else begin
          px_q[k+1] <= px_q[k] - (py_q[k] >>> k);
          py_q[k+1] <= py_q[k] + (px_q[k] >>> k);
          pz_q[k+1] <= pz_q[k] - atan_q24(k);
        end
        pyaw_q[k+1] <= pyaw_q[k];
        pflg_q[k+1] <= pflg_q[k];
      end
    end
  end

  // output register
  logic signed [AngleW-1:0] pr;
  logic [NpW-1:0]           np_q;
  logic [YawW-1:0]          yaw_q;

  assign pr = ((-pz_q[CordicSteps]) + Half) >>> Sh;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pflg_q[CordicSteps][1]) begin
        np_q  <= pflg_q[CordicSteps][0] ? P90 : P270;
        yaw_q <= '0;
      end else begin
        np_q  <= NpW'(pr);
        yaw_q <= pyaw_q[CordicSteps];
      end
    end
  end

  assign neg_pitch_o = np_q;
  assign yaw_angle_o = yaw_q;

endmodule
`default_nettype wire

@@ hw/rtl/vector_to_pitch_yaw_angles_core.sv @@
// result path: front register, queue, then the back pipeline with its two cordic passes
// throughput: one transfer per cycle per side unless stalled; back stages share one enable
// the front register and a two-entry queue let input and back pipeline stall apart
// reset: asynchronous, active low; clears valid flags and queue pointers, no datapath reset
`default_nettype none
module vector_to_pitch_yaw_angles_core import vpya_pkg::*; #(
  parameter int CoordWidth = CoordWidthDef,
  parameter int AngleFrac  = AngleFracDef,
  localparam int DW    = CoordWidth + 1,
  localparam int ItemW = 3 * DW + 1,
  localparam int InW   = ((NumCoords * CoordWidth + 7) / 8) * 8,
  localparam int NpW   = AngleFrac + 10,
  localparam int YawW  = AngleFrac + 9,
  localparam int OutW  = ((NpW + YawW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // target_x, target_y, target_z, eye_x, eye_y, eye_z, zero pad
  input  wire logic [InW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // neg_pitch, yaw_angle, zero pad
  output logic [OutW-1:0]      m_axis_tdata_o
);

  // front to queue
  logic             f_vld, f_rdy;
  logic [ItemW-1:0] f_item;
  // queue to back
  logic             q_vld, q_rdy;
  logic [ItemW-1:0] q_item;
  logic [NpW-1:0]   neg_pitch;
  logic [YawW-1:0]  yaw_angle;

  // differences and the no-horizontal-component check
  vpya_front #(.CoordWidth(CoordWidth)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .item_vld_o(f_vld), .item_rdy_i(f_rdy), .item_o(f_item)
  );

  // short queue, fall-through read
  vpya_fifo #(.Width(ItemW), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_vld_i(f_vld), .wr_rdy_o(f_rdy), .wr_data_i(f_item),
    .rd_vld_o(q_vld), .rd_rdy_i(q_rdy), .rd_data_o(q_item)
  );

  // normalise, yaw pass, gain correction, pitch pass, rounding
  vpya_back #(.CoordWidth(CoordWidth), .AngleFrac(AngleFrac)) u_back (
    .clk_i, .rst_ni,
    .item_vld_i(q_vld), .item_rdy_o(q_rdy), .item_i(q_item),
    .res_vld_o(m_axis_tvalid_o), .res_rdy_i(m_axis_tready_i),
    .neg_pitch_o(neg_pitch), .yaw_angle_o(yaw_angle)
  );

  assign m_axis_tdata_o = OutW'({yaw_angle, neg_pitch});

endmodule
`default_nettype wire

@@ dv/vector_to_pitch_yaw_angles_core_test.sv @@
`default_nettype none
module vector_to_pitch_yaw_angles_core_test;
  import vpya_pkg::*;

  localparam int CW    = CoordWidthDef;
  localparam int AF    = AngleFracDef;
  localparam int InW   = ((NumCoords * CW + 7) / 8) * 8;
  localparam int NpW   = AF + 10;
  localparam int YawW  = AF + 9;
  localparam int OutW  = ((NpW + YawW + 7) / 8) * 8;
  localparam int Latency = 2 * CordicSteps + 8;

  typedef struct packed {
    logic [NpW-1:0]  neg_pitch;
    logic [YawW-1:0] yaw_angle;
  } angles_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  // target_x, target_y, target_z, eye_x, eye_y, eye_z, zero pad
  logic [InW-1:0]  s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  // neg_pitch, yaw_angle, zero pad
  logic [OutW-1:0] m_axis_tdata_o;

  vector_to_pitch_yaw_angles_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #2 clk_i = ~clk_i;

  angles_t angle_queue[$];
  int      fail_count = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  bit      hold_off = 1'b0;
  bit      rx_quiet = 1'b0;

  localparam longint unsigned NormLimit = 64'd1 << 56;

  function automatic longint atan_step(int i);
    longint t[CordicSteps] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  // vectoring rotation, returns q.24 degrees and leaves the scaled length in vx
  function automatic longint rotate_to_axis(inout longint vx, input longint vy);
    longint acc, xs, ys;
    acc = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx += ys; vy -= xs; acc += atan_step(i);
      end else begin
        vx -= ys; vy += xs; acc -= atan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic longint round_deg(longint v);
    return (v + (64'sd1 <<< (IntFrac - AF - 1))) >>> (IntFrac - AF);
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic angles_t aim_angles(logic [InW-1:0] d);
    longint dx, dy, dz, x, y, z, r, zp, np, yw;
    longint unsigned m, xu;
    int s;
    angles_t a;
    dx = longint'($signed(d[0*CW +: CW])) - longint'($signed(d[3*CW +: CW]));
    dy = longint'($signed(d[1*CW +: CW])) - longint'($signed(d[4*CW +: CW]));
    dz = longint'($signed(d[2*CW +: CW])) - longint'($signed(d[5*CW +: CW]));
    if (dx == 0 && dy == 0) begin
      np = -(longint'(dz > 0 ? Deg90 : Deg270) <<< AF);
      yw = 0;
    end else begin
      m = abs64(dx);
      if (abs64(dy) > m) m = abs64(dy);
      if (abs64(dz) > m) m = abs64(dz);
      s = 0;
      while (s < 62 && ((m << s) << 1) < NormLimit) s++;
      dx = dx <<< s; dy = dy <<< s; dz = dz <<< s;
      x = dx < 0 ? -dx : dx;
      y = dx < 0 ? -dy : dy;
      z = rotate_to_axis(x, y);
      if (dx < 0) z += longint'(Deg180) <<< IntFrac;
      if (z < 0) z += longint'(Deg360) <<< IntFrac;
      yw = round_deg(z);
      if (yw >= (longint'(Deg360) <<< AF)) yw -= longint'(Deg360) <<< AF;
      xu = x < 0 ? 0 : x;
      r = (xu >> 30) * 652032874 + (((xu & ((64'd1 << 30) - 1)) * 652032874
          + (64'd1 << 29)) >> 30);
      zp = rotate_to_axis(r, dz);
      np = round_deg(-zp);
    end
    a.neg_pitch = np[NpW-1:0];
    a.yaw_angle = yw[YawW-1:0];
    return a;
  endfunction

  function automatic logic [InW-1:0] pack_points(longint tx, longint ty, longint tz,
                                                 longint ex, longint ey, longint ez);
    logic [InW-1:0] d;
    d = '0;
    d[0*CW +: CW] = tx[CW-1:0]; d[1*CW +: CW] = ty[CW-1:0];
    d[2*CW +: CW] = tz[CW-1:0]; d[3*CW +: CW] = ex[CW-1:0];
    d[4*CW +: CW] = ey[CW-1:0]; d[5*CW +: CW] = ez[CW-1:0];
    return d;
  endfunction

  // one input transfer, prediction queued on acceptance
  // valid stays up after the transfer until the next item or a drain takes over
  task automatic send_points(logic [InW-1:0] d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8));
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    angle_queue.push_back(aim_angles(d));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (Latency + 8) @(negedge clk_i);
  endtask

  // receiver stalls, drawn per result; a long hold-off can be forced
  always @(negedge clk_i) begin : rx_ready
    int wait_cnt;
    if (hold_off || wait_cnt > 0) begin
      m_axis_tready_i <= 1'b0;
      if (wait_cnt > 0) wait_cnt--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (m_axis_tvalid_o && m_axis_tready_i && !rx_quiet)
        wait_cnt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
    end
  end

  always @(posedge clk_i) begin : result_check
    angles_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[NpW-1:0], m_axis_tdata_o[NpW +: YawW]};
      results_seen++;
      if (angle_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata_o);
        fail_count++;
      end else begin
        want = angle_queue.pop_front();
        if (got.neg_pitch !== want.neg_pitch) begin
          $display("%0t neg_pitch expected %h actual %h", $time, want.neg_pitch,
                   got.neg_pitch);
          fail_count++;
        end
        if (got.yaw_angle !== want.yaw_angle) begin
          $display("%0t yaw_angle expected %h actual %h", $time, want.yaw_angle,
                   got.yaw_angle);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_points(pack_points(0, 0, 0, 0, 0, 0));
    send_points(pack_points(0, 0, 5, 0, 0, 0));
    send_points(pack_points(0, 0, -5, 0, 0, 0));
    send_points(pack_points(7, 7, mx, 7, 7, mn));
    send_points(pack_points(7, 7, mn, 7, 7, mx));
    send_points(pack_points(256, 0, 0, 0, 0, 0));
    send_points(pack_points(0, 256, 0, 0, 0, 0));
    send_points(pack_points(-256, 0, 0, 0, 0, 0));
    send_points(pack_points(0, -256, 0, 0, 0, 0));
    send_points(pack_points(-256, -1, 0, 0, 0, 0));
    send_points(pack_points(1, -1, 0, 0, 0, 0));
    send_points(pack_points(1, 0, 0, 0, 0, 0));
    send_points(pack_points(mx, mx, mx, mn, mn, mn));
    send_points(pack_points(mn, mn, mn, mx, mx, mx));
    send_points(pack_points(mx, 0, mn, mn, 0, mx));
    send_points(pack_points(-1, -1, -1, -1, -1, -1));
    send_points(pack_points(mn, 0, 0, mn, 1, 0));
    send_points(pack_points(100, 100, 100, 0, 0, 0));
    send_points(pack_points(0, 0, 1, 1, 0, 0));
    send_points(pack_points(mx, mn, 3, 0, 0, 3));
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(0, 3))
      0: return longint'($signed($urandom()));
      1: return longint'($signed($urandom_range(0, 2000))) - 1000;
      2: return longint'($signed($urandom())) >>> $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
    endcase
  endfunction

  task automatic test_random(int n);
    longint ex, ey, ez;
    for (int i = 0; i < n; i++) begin
      ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
      // sometimes a shared x/y so the degenerate case turns up
      if ($urandom_range(0, 15) == 0)
        send_points(pack_points(ex, ey, rand_coord(), ex, ey, ez), i % 50 < 10);
      else
        send_points(pack_points(rand_coord(), rand_coord(), rand_coord(), ex, ey, ez),
                    i % 50 < 10);
    end
  endtask

  // stall the output long enough for the pipeline to back up into the input
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin repeat (200) @(negedge clk_i); hold_off = 1'b0; end
      for (int i = 0; i < 120; i++)
        send_points(pack_points(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord()), 1);
    join
  endtask

  task automatic test_streaming();
    rx_quiet = 1'b1;
    drain_results();
    for (int i = 0; i < 200; i++)
      send_points(pack_points(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord()), 1);
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    drain_results();
    test_random(1000);
    test_backpressure();
    test_streaming();
    drain_results();
    $display("sent %0d vectors incl. degenerate, extreme and stalled cases; checked %0d",
             items_sent, results_seen);
    if (fail_count == 0 && angle_queue.size() == 0)
      $display("vector_to_pitch_yaw_angles_core: match");
    else
      $display("vector_to_pitch_yaw_angles_core: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("vector_to_pitch_yaw_angles_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/vpya_pkg.sv
hw/rtl/vpya_front.sv
hw/rtl/vpya_fifo.sv
hw/rtl/vpya_back.sv
hw/rtl/vector_to_pitch_yaw_angles_core.sv
dv/vector_to_pitch_yaw_angles_core_test.sv
